// ----- hdl/tvna_pkg.sv -----
// Shared types, codes and tables for the two-voice note allocator.
package tvna_pkg;

    localparam int NOTE_COUNT      = 8;
    localparam int VOLUME_LEVELS   = 6;
    localparam int FREQ_TABLE_SIZE = 8;
    localparam int VOL_TABLE_SIZE  = 6;

    // Highest usable volume level.
    localparam int VOL_TOP_I  = ((VOLUME_LEVELS - 1) < (VOL_TABLE_SIZE - 1)) ?
                                (VOLUME_LEVELS - 1) : (VOL_TABLE_SIZE - 1);
    localparam logic [2:0] VOL_TOP = 3'(VOL_TOP_I);

    localparam logic [3:0]  NO_NOTE        = 4'd8;
    localparam logic [15:0] FADE_TICKS_RST = 16'd24;
    localparam logic [3:0]  VOLUME_RST     = 4'd1;

    localparam logic [10:0] FREQ_TABLE [FREQ_TABLE_SIZE] =
        '{11'd523, 11'd587, 11'd659, 11'd698, 11'd784, 11'd880, 11'd988, 11'd1046};
    // 720000 / freq - 1 for each table entry
    localparam logic [10:0] DIV_TABLE [FREQ_TABLE_SIZE] =
        '{11'd1375, 11'd1225, 11'd1091, 11'd1030, 11'd917, 11'd817, 11'd727, 11'd687};
    localparam logic [3:0] VOL_TABLE [VOL_TABLE_SIZE] =
        '{4'd0, 4'd1, 4'd3, 4'd6, 4'd10, 4'd15};

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2,
        ACT_VOLUME   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SOUND = 2'd1,
        MODE_FADE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        LAST_NONE   = 2'd0,
        LAST_FIRST  = 2'd1,
        LAST_SECOND = 2'd2
    } last_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_NEXT,
        ST_LOAD,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       exec;
        logic       div_load;
        logic       div_step;
        logic       last_step;
        logic       load_out;
        logic       voice;
        logic [1:0] step;
    } cmd_t;

    typedef struct packed {
        logic [1:0] pend;
        logic       out_free;
    } status_t;

    function automatic logic [10:0] freq_of(input logic [3:0] n);
        logic [10:0] f;
        f = n[3] ? 11'd0 : FREQ_TABLE[n[2:0]];
        return f;
    endfunction

    function automatic logic [10:0] div_of(input logic [3:0] n);
        logic [10:0] d;
        d = n[3] ? 11'd0 : DIV_TABLE[n[2:0]];
        return d;
    endfunction

endpackage

// ----- hdl/tvna_ctrl.sv -----
// Sequencer: input capture, update, fade divisions and output load.
module tvna_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tvna_pkg::status_t status,
    output tvna_pkg::cmd_t   cmd
);
    import tvna_pkg::*;

    state_t     state_reg, state_next;
    logic       voice_reg, voice_next;
    logic [1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            voice_reg <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            voice_reg <= voice_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        voice_next = voice_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_NEXT;
            ST_NEXT: begin
                if (status.pend[0]) begin
                    voice_next = 1'b0;
                    state_next = ST_LOAD;
                end else if (status.pend[1]) begin
                    voice_next = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD: begin
                step_next  = 2'd3;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                step_next = step_reg - 2'd1;
                if (step_reg == 2'd0) state_next = ST_NEXT;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.voice = voice_reg;
        cmd.step  = step_reg;
        s_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: cmd.exec = 1'b1;
            ST_NEXT: ;
            ST_LOAD: cmd.div_load = 1'b1;
            ST_STEP: begin
                cmd.div_step  = 1'b1;
                cmd.last_step = (step_reg == 2'd0);
            end
            ST_DONE: cmd.load_out = status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- hdl/tvna_datapath.sv -----
// Voice state, allocation logic, shared fade-duty divider and output register.
module tvna_datapath #(
    parameter int NOTE_COUNT    = tvna_pkg::NOTE_COUNT,
    parameter int VOLUME_LEVELS = tvna_pkg::VOLUME_LEVELS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tvna_pkg::cmd_t    cmd,
    output tvna_pkg::status_t status,
    input  logic [1:0]        s_action,
    input  logic [2:0]        s_note,
    input  logic [2:0]        s_level,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [1:0]        m_first_voice_state,
    output logic [10:0]       m_first_voice_freq_hz,
    output logic [10:0]       m_first_voice_divider,
    output logic [3:0]        m_first_voice_duty,
    output logic [1:0]        m_second_voice_state,
    output logic [10:0]       m_second_voice_freq_hz,
    output logic [10:0]       m_second_voice_divider,
    output logic [3:0]        m_second_voice_duty
);
    import tvna_pkg::*;

    // highest usable note index plus one, and highest usable volume level
    localparam int NOTE_LIMIT = (NOTE_COUNT < FREQ_TABLE_SIZE) ? NOTE_COUNT : FREQ_TABLE_SIZE;
    localparam int LEVEL_TOP_I = ((VOLUME_LEVELS - 1) < (VOL_TABLE_SIZE - 1)) ?
                                 (VOLUME_LEVELS - 1) : (VOL_TABLE_SIZE - 1);
    localparam logic [2:0] LEVEL_TOP = 3'(LEVEL_TOP_I);

    // captured input word
    action_t    act_reg;
    logic [2:0] note_in_reg;
    logic [2:0] level_reg;

    logic [15:0] len_reg;
    mode_t       mode_reg [2];
    mode_t       mode_next [2];
    logic [3:0]  note_reg [2];
    logic [3:0]  note_next [2];
    logic [3:0]  duty_reg [2];
    logic [3:0]  duty_next [2];
    logic [15:0] elap_reg [2];
    logic [15:0] elap_next [2];
    last_t       last_reg, last_next;
    logic [3:0]  vol_reg, vol_next;
    logic [1:0]  pend_reg, pend_next;

    // divider
    logic [19:0] rem_reg;
    logic [2:0]  quo_reg;
    logic [19:0] div_sh;
    logic        q_bit;

    logic [16:0] t_inc [2];
    logic        note_ok;
    logic [2:0]  level_sat;
    logic        m_valid_reg;

    assign note_ok   = (32'(note_in_reg) < NOTE_LIMIT);
    assign level_sat = (level_reg > LEVEL_TOP) ? LEVEL_TOP : level_reg;
    assign div_sh    = 20'(len_reg) << cmd.step;
    assign q_bit     = (rem_reg >= div_sh);

    always_comb begin
        for (int v = 0; v < 2; v++) begin
            t_inc[v] = {1'b0, elap_reg[v]} + 17'd1;
        end
    end

    always_comb begin
        for (int v = 0; v < 2; v++) begin
            mode_next[v] = mode_reg[v];
            note_next[v] = note_reg[v];
            duty_next[v] = duty_reg[v];
            elap_next[v] = elap_reg[v];
        end
        last_next = last_reg;
        vol_next  = vol_reg;
        pend_next = pend_reg;

        if (cmd.exec) begin
            pend_next = 2'b00;
            case (act_reg)
                ACT_TICK: begin
                    for (int v = 0; v < 2; v++) begin
                        if (mode_reg[v] == MODE_FADE) begin
                            if (t_inc[v] > {1'b0, len_reg}) begin
                                mode_next[v] = MODE_IDLE;
                                duty_next[v] = 4'd0;
                            end else begin
                                elap_next[v] = t_inc[v][15:0];
                                pend_next[v] = 1'b1;
                            end
                        end
                    end
                end
                ACT_NOTE_ON: begin
                    if (note_ok) begin
                        if (mode_reg[0] == MODE_IDLE) begin
                            mode_next[0] = MODE_SOUND;
                            note_next[0] = {1'b0, note_in_reg};
                            duty_next[0] = vol_reg;
                            elap_next[0] = 16'd0;
                            last_next    = LAST_FIRST;
                        end else if (mode_reg[1] == MODE_IDLE) begin
                            mode_next[1] = MODE_SOUND;
                            note_next[1] = {1'b0, note_in_reg};
                            duty_next[1] = vol_reg;
                            elap_next[1] = 16'd0;
                            last_next    = LAST_SECOND;
                        end else if (mode_reg[0] == MODE_FADE) begin
                            mode_next[0] = MODE_SOUND;
                            note_next[0] = {1'b0, note_in_reg};
                            duty_next[0] = vol_reg;
                            elap_next[0] = 16'd0;
                            last_next    = LAST_FIRST;
                        end else if (mode_reg[1] == MODE_FADE) begin
                            mode_next[1] = MODE_SOUND;
                            note_next[1] = {1'b0, note_in_reg};
                            duty_next[1] = vol_reg;
                            elap_next[1] = 16'd0;
                            last_next    = LAST_SECOND;
                        end else if (last_reg == LAST_FIRST) begin
                            // steal: only the pitch changes
                            note_next[1] = {1'b0, note_in_reg};
                            last_next    = LAST_SECOND;
                        end else begin
                            note_next[0] = {1'b0, note_in_reg};
                            last_next    = LAST_FIRST;
                        end
                    end
                end
                ACT_NOTE_OFF: begin
                    if (note_ok) begin
                        if (mode_reg[0] == MODE_SOUND && note_reg[0] == {1'b0, note_in_reg}) begin
                            mode_next[0] = MODE_FADE;
                            elap_next[0] = 16'd0;
                            if (last_reg == LAST_FIRST) begin
                                last_next = (mode_reg[1] == MODE_IDLE) ? LAST_NONE : LAST_SECOND;
                            end
                        end else if (mode_reg[1] == MODE_SOUND &&
                                     note_reg[1] == {1'b0, note_in_reg}) begin
                            mode_next[1] = MODE_FADE;
                            elap_next[1] = 16'd0;
                            if (last_reg == LAST_SECOND) begin
                                last_next = (mode_reg[0] == MODE_IDLE) ? LAST_NONE : LAST_FIRST;
                            end
                        end
                    end
                end
                ACT_VOLUME: begin
                    vol_next = VOL_TABLE[level_sat];
                    for (int v = 0; v < 2; v++) begin
                        mode_next[v] = MODE_IDLE;
                        duty_next[v] = 4'd0;
                        elap_next[v] = 16'd0;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.div_step && cmd.last_step) begin
            duty_next[cmd.voice] = {quo_reg, q_bit};
            pend_next[cmd.voice] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= FADE_TICKS_RST;
            last_reg <= LAST_NONE;
            vol_reg  <= VOLUME_RST;
            pend_reg <= 2'b00;
            for (int v = 0; v < 2; v++) begin
                mode_reg[v] <= MODE_IDLE;
                note_reg[v] <= NO_NOTE;
                duty_reg[v] <= 4'd0;
                elap_reg[v] <= 16'd0;
            end
        end else begin
            if (cfg_wr_en) len_reg <= cfg_wr_data;
            last_reg <= last_next;
            vol_reg  <= vol_next;
            pend_reg <= pend_next;
            for (int v = 0; v < 2; v++) begin
                mode_reg[v] <= mode_next[v];
                note_reg[v] <= note_next[v];
                duty_reg[v] <= duty_next[v];
                elap_reg[v] <= elap_next[v];
            end
        end
    end

    // input word capture and the restoring divider, payload only
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg     <= action_t'(s_action);
            note_in_reg <= s_note;
            level_reg   <= s_level;
        end
        if (cmd.div_load) begin
            rem_reg <= 20'(vol_reg) * 20'(len_reg - elap_reg[cmd.voice]);
            quo_reg <= 3'd0;
        end else if (cmd.div_step) begin
            if (q_bit) rem_reg <= rem_reg - div_sh;
            quo_reg <= {quo_reg[1:0], q_bit};
        end
    end

    // output register: holds a finished word while the next one is worked on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_first_voice_state     <= mode_reg[0];
            m_first_voice_freq_hz   <= freq_of(note_reg[0]);
            m_first_voice_divider   <= div_of(note_reg[0]);
            m_first_voice_duty      <= duty_reg[0];
            m_second_voice_state    <= mode_reg[1];
            m_second_voice_freq_hz  <= freq_of(note_reg[1]);
            m_second_voice_divider  <= div_of(note_reg[1]);
            m_second_voice_duty     <= duty_reg[1];
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.pend     = pend_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    a_idle_quiet_0: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg[0] == MODE_IDLE |-> duty_reg[0] == 4'd0)
        else $error("first voice idle with nonzero duty");
    a_idle_quiet_1: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg[1] == MODE_IDLE |-> duty_reg[1] == 4'd0)
        else $error("second voice idle with nonzero duty");
    a_duty_cap_0: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg[0] <= vol_reg)
        else $error("first voice duty above volume");
    a_duty_cap_1: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg[1] <= vol_reg)
        else $error("second voice duty above volume");
    a_div_fading: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |-> mode_reg[cmd.voice] == MODE_FADE && pend_reg[cmd.voice])
        else $error("fade division started on a voice that is not fading");

endmodule

// ----- hdl/two_voice_note_allocator_with_fade.sv -----
// Top level of the two-voice note allocator with release fade.
// Each input word (tick, note on, note off, set volume) produces one output word with
// the state, frequency, timer divider and duty of both voices. On a tick, each voice
// still fading gets its duty from a shared 4-step restoring divider, one voice after
// the other, before the word is loaded into the output register. The input is taken
// again once the result is in the output register, while that word still waits for
// m_ready; a result that finds the output register still full waits for m_ready.
// fade_ticks is written through cfg_wr_en/cfg_wr_data and resets to 24.
module two_voice_note_allocator_with_fade #(
    parameter int NOTE_COUNT    = tvna_pkg::NOTE_COUNT,
    parameter int VOLUME_LEVELS = tvna_pkg::VOLUME_LEVELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [2:0]  s_note,
    input  logic [2:0]  s_level,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_first_voice_state,
    output logic [10:0] m_first_voice_freq_hz,
    output logic [10:0] m_first_voice_divider,
    output logic [3:0]  m_first_voice_duty,
    output logic [1:0]  m_second_voice_state,
    output logic [10:0] m_second_voice_freq_hz,
    output logic [10:0] m_second_voice_divider,
    output logic [3:0]  m_second_voice_duty
);
    import tvna_pkg::*;

    cmd_t    cmd;
    status_t status;

    tvna_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tvna_datapath #(
        .NOTE_COUNT    (NOTE_COUNT),
        .VOLUME_LEVELS (VOLUME_LEVELS)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .status                 (status),
        .s_action               (s_action),
        .s_note                 (s_note),
        .s_level                (s_level),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_wr_data            (cfg_wr_data),
        .m_ready                (m_ready),
        .m_valid                (m_valid),
        .m_first_voice_state    (m_first_voice_state),
        .m_first_voice_freq_hz  (m_first_voice_freq_hz),
        .m_first_voice_divider  (m_first_voice_divider),
        .m_first_voice_duty     (m_first_voice_duty),
        .m_second_voice_state   (m_second_voice_state),
        .m_second_voice_freq_hz (m_second_voice_freq_hz),
        .m_second_voice_divider (m_second_voice_divider),
        .m_second_voice_duty    (m_second_voice_duty)
    );

endmodule

// ----- test/two_voice_note_allocator_with_fade_tb.sv -----
// Self-checking testbench for the two-voice note allocator: directed table, then random phases.
module two_voice_note_allocator_with_fade_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tvna_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_WORDS  = 160;
    localparam int PHASE_COUNT  = 7;
    localparam int DIRECTED_LEN = 25;
    localparam int unsigned TIMER_HZ = 720000;

    typedef struct packed {
        mode_t       state;
        logic [10:0] freq;
        logic [10:0] div;
        logic [3:0]  duty;
    } voice_out_t;

    typedef struct packed {
        voice_out_t first;
        voice_out_t second;
    } mix_out_t;

    typedef struct packed {
        action_t    act;
        logic [2:0] note;
        logic [2:0] level;
        logic       typed;
        mix_out_t   want;
    } dir_row_t;

    localparam voice_out_t QUIET  = '{MODE_IDLE, 11'd0, 11'd0, 4'd0};
    localparam voice_out_t C5_TOP = '{MODE_SOUND, 11'd523, 11'd1375, 4'd15};
    localparam voice_out_t C6_TOP = '{MODE_SOUND, 11'd1046, 11'd687, 4'd15};

    // Rows with typed = 0 are checked against the predictor only.
    localparam dir_row_t DIRECTED [DIRECTED_LEN] = '{
        '{ACT_TICK,     3'd0, 3'd0, 1'b1, '{QUIET, QUIET}},
        '{ACT_NOTE_OFF, 3'd3, 3'd0, 1'b1, '{QUIET, QUIET}},
        '{ACT_VOLUME,   3'd0, 3'd7, 1'b1, '{QUIET, QUIET}},
        '{ACT_NOTE_ON,  3'd0, 3'd0, 1'b1, '{C5_TOP, QUIET}},
        '{ACT_NOTE_ON,  3'd7, 3'd0, 1'b1, '{C5_TOP, C6_TOP}},
        '{ACT_NOTE_ON,  3'd3, 3'd0, 1'b0, '0},
        '{ACT_NOTE_ON,  3'd5, 3'd0, 1'b0, '0},
        '{ACT_NOTE_OFF, 3'd5, 3'd0, 1'b0, '0},
        '{ACT_TICK,     3'd0, 3'd0, 1'b0, '0},
        '{ACT_NOTE_ON,  3'd2, 3'd0, 1'b0, '0},
        '{ACT_NOTE_OFF, 3'd3, 3'd0, 1'b0, '0},
        '{ACT_NOTE_OFF, 3'd2, 3'd0, 1'b0, '0},
        '{ACT_TICK,     3'd0, 3'd0, 1'b0, '0},
        '{ACT_VOLUME,   3'd0, 3'd0, 1'b0, '0},
        '{ACT_NOTE_ON,  3'd1, 3'd0, 1'b0, '0},
        '{ACT_NOTE_OFF, 3'd1, 3'd0, 1'b0, '0},
        '{ACT_TICK,     3'd0, 3'd0, 1'b0, '0},
        '{ACT_VOLUME,   3'd0, 3'd5, 1'b0, '0},
        '{ACT_NOTE_ON,  3'd4, 3'd0, 1'b0, '0},
        '{ACT_NOTE_ON,  3'd6, 3'd0, 1'b0, '0},
        '{ACT_NOTE_OFF, 3'd6, 3'd0, 1'b0, '0},
        '{ACT_TICK,     3'd0, 3'd0, 1'b0, '0},
        '{ACT_TICK,     3'd0, 3'd0, 1'b0, '0},
        '{ACT_NOTE_ON,  3'd6, 3'd0, 1'b0, '0},
        '{ACT_VOLUME,   3'd0, 3'd2, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [2:0]  s_note;
    logic [2:0]  s_level;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_first_voice_state;
    logic [10:0] m_first_voice_freq_hz;
    logic [10:0] m_first_voice_divider;
    logic [3:0]  m_first_voice_duty;
    logic [1:0]  m_second_voice_state;
    logic [10:0] m_second_voice_freq_hz;
    logic [10:0] m_second_voice_divider;
    logic [3:0]  m_second_voice_duty;

    two_voice_note_allocator_with_fade i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_action               (s_action),
        .s_note                 (s_note),
        .s_level                (s_level),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_wr_data            (cfg_wr_data),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_first_voice_state    (m_first_voice_state),
        .m_first_voice_freq_hz  (m_first_voice_freq_hz),
        .m_first_voice_divider  (m_first_voice_divider),
        .m_first_voice_duty     (m_first_voice_duty),
        .m_second_voice_state   (m_second_voice_state),
        .m_second_voice_freq_hz (m_second_voice_freq_hz),
        .m_second_voice_divider (m_second_voice_divider),
        .m_second_voice_duty    (m_second_voice_duty)
    );

    // Allocator mirror
    mode_t       chan_mode [2];
    logic [3:0]  chan_note [2];
    logic [3:0]  chan_duty [2];
    logic [16:0] chan_age  [2];
    last_t       recent_chan;
    logic [3:0]  level_duty;
    logic [15:0] release_len;

    logic [10:0] pitch_hz   [8] = '{11'd523, 11'd587, 11'd659, 11'd698,
                                    11'd784, 11'd880, 11'd988, 11'd1046};
    logic [3:0]  level_map  [6] = '{4'd0, 4'd1, 4'd3, 4'd6, 4'd10, 4'd15};

    mix_out_t pending_mix [$];
    int       error_count = 0;
    int       cycle_count = 0;
    bit       idling_on   = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic mirror_reset();
        for (int v = 0; v < 2; v++) begin
            chan_mode[v] = MODE_IDLE;
            chan_note[v] = NO_NOTE;
            chan_duty[v] = 4'd0;
            chan_age[v]  = 17'd0;
        end
        recent_chan = LAST_NONE;
        level_duty  = 4'd1;
        release_len = 16'd24;
    endtask

    task automatic launch_voice(input int v, input logic [2:0] n);
        chan_note[v] = {1'b0, n};
        chan_mode[v] = MODE_SOUND;
        chan_duty[v] = level_duty;
        chan_age[v]  = 17'd0;
        recent_chan  = (v == 0) ? LAST_FIRST : LAST_SECOND;
    endtask

    task automatic step_allocator(input action_t act, input logic [2:0] n,
                                  input logic [2:0] lvl, output mix_out_t res);
        logic [16:0] t;
        logic [2:0]  sat;
        int unsigned num;
        logic [10:0] f;
        voice_out_t  vo [2];
        bit          found;
        case (act)
            ACT_TICK: begin
                for (int v = 0; v < 2; v++) begin
                    if (chan_mode[v] == MODE_FADE) begin
                        t = chan_age[v];
                        if (t <= {1'b0, release_len}) t = t + 17'd1;
                        chan_age[v] = t;
                        if (t > {1'b0, release_len}) begin
                            chan_mode[v] = MODE_IDLE;
                            chan_duty[v] = 4'd0;
                        end else begin
                            num = int'(level_duty) * (int'(release_len) - int'(t));
                            chan_duty[v] = 4'(num / int'(release_len));
                        end
                    end
                end
            end
            ACT_NOTE_ON: begin
                if (int'(n) < NOTE_COUNT) begin
                    if (chan_mode[0] == MODE_IDLE) launch_voice(0, n);
                    else if (chan_mode[1] == MODE_IDLE) launch_voice(1, n);
                    else if (chan_mode[0] == MODE_FADE) launch_voice(0, n);
                    else if (chan_mode[1] == MODE_FADE) launch_voice(1, n);
                    else if (recent_chan == LAST_FIRST) begin
                        // steal: pitch changes, duty and mode stay
                        chan_note[1] = {1'b0, n};
                        recent_chan  = LAST_SECOND;
                    end else begin
                        chan_note[0] = {1'b0, n};
                        recent_chan  = LAST_FIRST;
                    end
                end
            end
            ACT_NOTE_OFF: begin
                found = 1'b0;
                if (int'(n) < NOTE_COUNT) begin
                    for (int v = 0; v < 2; v++) begin
                        if (!found && chan_mode[v] == MODE_SOUND &&
                            chan_note[v] == {1'b0, n}) begin
                            found        = 1'b1;
                            chan_mode[v] = MODE_FADE;
                            chan_age[v]  = 17'd0;
                            if (recent_chan == ((v == 0) ? LAST_FIRST : LAST_SECOND)) begin
                                if (chan_mode[1 - v] == MODE_IDLE) recent_chan = LAST_NONE;
                                else recent_chan = (v == 0) ? LAST_SECOND : LAST_FIRST;
                            end
                        end
                    end
                end
            end
            default: begin
                sat        = (lvl > VOL_TOP) ? VOL_TOP : lvl;
                level_duty = level_map[sat];
                for (int v = 0; v < 2; v++) begin
                    chan_mode[v] = MODE_IDLE;
                    chan_duty[v] = 4'd0;
                    chan_age[v]  = 17'd0;
                end
            end
        endcase
        for (int v = 0; v < 2; v++) begin
            f = chan_note[v][3] ? 11'd0 : pitch_hz[chan_note[v][2:0]];
            vo[v].state = chan_mode[v];
            vo[v].freq  = f;
            vo[v].div   = (f != 11'd0) ? 11'(TIMER_HZ / int'(f) - 1) : 11'd0;
            vo[v].duty  = chan_duty[v];
        end
        res.first  = vo[0];
        res.second = vo[1];
    endtask

    // Drive one word, wait for its handshake and queue its expected output.
    task automatic send_word(input action_t act, input logic [2:0] n, input logic [2:0] lvl,
                             input logic typed, input mix_out_t typed_want);
        mix_out_t predicted;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_note   <= n;
        s_level  <= lvl;
        do @(posedge aclk); while (!s_ready);
        step_allocator(act, n, lvl, predicted);
        pending_mix.push_back(typed ? typed_want : predicted);
    endtask

    function automatic logic [2:0] release_pick();
        int v;
        v = $urandom_range(0, 1);
        // mostly release a note that a voice holds or last held
        if ($urandom_range(0, 3) != 0 && !chan_note[v][3]) return chan_note[v][2:0];
        return 3'($urandom_range(0, 7));
    endfunction

    task automatic send_random_word();
        int      pick;
        action_t act;
        logic [2:0] n;
        pick = $urandom_range(0, 99);
        if (pick < 45) act = ACT_TICK;
        else if (pick < 72) act = ACT_NOTE_ON;
        else if (pick < 95) act = ACT_NOTE_OFF;
        else act = ACT_VOLUME;
        n = (act == ACT_NOTE_OFF) ? release_pick() : 3'($urandom_range(0, 7));
        send_word(act, n, 3'($urandom_range(0, 7)), 1'b0, '0);
    endtask

    task automatic drain_and_write(input logic [15:0] len);
        s_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        release_len = len;
    endtask

    task automatic check_voice(input string tag, input voice_out_t want, input voice_out_t got);
        if (want.state != got.state) begin
            $display("%0t: %s state expected %0d got %0d", $time, tag, want.state, got.state);
            error_count++;
        end
        if (want.freq != got.freq) begin
            $display("%0t: %s freq expected %0d got %0d", $time, tag, want.freq, got.freq);
            error_count++;
        end
        if (want.div != got.div) begin
            $display("%0t: %s divider expected %0d got %0d", $time, tag, want.div, got.div);
            error_count++;
        end
        if (want.duty != got.duty) begin
            $display("%0t: %s duty expected %0d got %0d", $time, tag, want.duty, got.duty);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        mix_out_t got;
        mix_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got.first  = '{mode_t'(m_first_voice_state), m_first_voice_freq_hz,
                           m_first_voice_divider, m_first_voice_duty};
            got.second = '{mode_t'(m_second_voice_state), m_second_voice_freq_hz,
                           m_second_voice_divider, m_second_voice_duty};
            if (pending_mix.size() == 0) begin
                $display("%0t: output word with none expected, got %h", $time, got);
                error_count++;
            end else begin
                want = pending_mix.pop_front();
                check_voice("first voice", want.first, got.first);
                check_voice("second voice", want.second, got.second);
            end
        end
    end

    // Result side: random stall bursts while idling is on.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (idling_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        logic [15:0] phase_len [PHASE_COUNT];
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_action    <= ACT_TICK;
        s_note      <= 3'd0;
        s_level     <= 3'd0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 16'd0;
        mirror_reset();
        phase_len = '{16'd3, 16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(4, 40)), 16'd2, 16'd24};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_word(DIRECTED[i].act, DIRECTED[i].note, DIRECTED[i].level,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_and_write(phase_len[p]);
            // no idling in the closing phase
            if (p == PHASE_COUNT - 1) idling_on = 1'b0;
            for (int k = 0; k < PHASE_WORDS; k++) send_random_word();
        end

        s_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (error_count == 0 && pending_mix.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
